// ----- hw/rtl/ccrq_pkg.sv -----
`default_nettype none

package ccrq_pkg;

   // Frame geometry, fixed at build time.
   localparam int SRC_COLS      = 320;
   localparam int SRC_ROWS      = 240;
   localparam int TARGET_WIDTH  = 96;
   localparam int TARGET_HEIGHT = 96;

   // Centered crop with the target aspect ratio, in integer arithmetic.
   localparam int SW_TH = SRC_COLS * TARGET_HEIGHT;
   localparam int SH_TW = SRC_ROWS * TARGET_WIDTH;
   localparam int CROP_W = (SW_TH > SH_TW) ? SH_TW / TARGET_HEIGHT : SRC_COLS;
   localparam int CROP_H = (SW_TH < SH_TW) ? SW_TH / TARGET_WIDTH : SRC_ROWS;
   localparam int CROP_X = (SRC_COLS - CROP_W) / 2;
   localparam int CROP_Y = (SRC_ROWS - CROP_H) / 2;

   // Per destination step: whole part and remainder of crop / target.
   localparam int COL_STEP = CROP_W / TARGET_WIDTH;
   localparam int COL_REM  = CROP_W % TARGET_WIDTH;
   localparam int ROW_STEP = CROP_H / TARGET_HEIGHT;
   localparam int ROW_REM  = CROP_H % TARGET_HEIGHT;

   // Counter widths.
   localparam int COL_W  = $clog2(SRC_COLS + 1);
   localparam int ROW_W  = $clog2(SRC_ROWS + 1);
   localparam int DCOL_W = $clog2(TARGET_WIDTH + 1);
   localparam int DROW_W = $clog2(TARGET_HEIGHT + 1);
   localparam int CREM_W = $clog2(TARGET_WIDTH + 1);
   localparam int RREM_W = $clog2(TARGET_HEIGHT + 1);

   // Quantizer widths.
   localparam int PIX_W   = 8;
   localparam int SCALE_W = 24;
   localparam int PROD_W  = PIX_W + SCALE_W;
   localparam int FRAC_W  = 16;
   localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(1 << FRAC_W);

   // Configuration register indexes.
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_SCALE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_POINT = 1'b1;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic signed [7:0] q_red;
      logic signed [7:0] q_green;
      logic signed [7:0] q_blue;
      logic              frame_last;
   } rsp_type;

   // Sampling decision for the pixel currently presented.
   typedef struct packed {
      logic keep;
      logic last;
   } sample_type;

   // Pipeline enables shared by the channel lanes.
   typedef struct packed {
      logic load_prod;
      logic load_out;
   } lane_ctrl_type;

endpackage

`default_nettype wire

// ----- hw/rtl/ccrq_sampler.sv -----
`default_nettype none

module ccrq_sampler
   import ccrq_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic       frame_start,
   output sample_type      sample
);

   logic [COL_W-1:0]  src_col_ff,  src_col_in;
   logic [ROW_W-1:0]  src_row_ff,  src_row_in;
   logic [DCOL_W-1:0] dst_col_ff,  dst_col_in;
   logic [DROW_W-1:0] dst_row_ff,  dst_row_in;
   logic [COL_W-1:0]  nk_col_ff,   nk_col_in;
   logic [ROW_W-1:0]  nk_row_ff,   nk_row_in;
   logic [CREM_W-1:0] col_rem_ff,  col_rem_in;
   logic [RREM_W-1:0] row_rem_ff,  row_rem_in;

   // Position after an optional frame restart.
   logic [COL_W-1:0]  src_col;
   logic [ROW_W-1:0]  src_row;
   logic [DCOL_W-1:0] dst_col;
   logic [DROW_W-1:0] dst_row;
   logic [COL_W-1:0]  nk_col;
   logic [ROW_W-1:0]  nk_row;
   logic [CREM_W-1:0] col_rem;
   logic [RREM_W-1:0] row_rem;

   logic              row_kept;
   logic              keep;
   logic [CREM_W:0]   col_rem_sum;
   logic [RREM_W:0]   row_rem_sum;

   always_comb begin
      src_col = frame_start ? '0 : src_col_ff;
      src_row = frame_start ? '0 : src_row_ff;
      dst_col = frame_start ? '0 : dst_col_ff;
      dst_row = frame_start ? '0 : dst_row_ff;
      nk_col  = frame_start ? COL_W'(CROP_X) : nk_col_ff;
      nk_row  = frame_start ? ROW_W'(CROP_Y) : nk_row_ff;
      col_rem = frame_start ? '0 : col_rem_ff;
      row_rem = frame_start ? '0 : row_rem_ff;

      row_kept = (dst_row < DROW_W'(TARGET_HEIGHT)) && (src_row == nk_row);
      keep = row_kept && (dst_col < DCOL_W'(TARGET_WIDTH)) && (src_col == nk_col);

      sample.keep = keep;
      sample.last = (dst_row == DROW_W'(TARGET_HEIGHT - 1))
                 && (dst_col == DCOL_W'(TARGET_WIDTH - 1));

      col_rem_sum = {1'b0, col_rem} + (CREM_W + 1)'(COL_REM);
      row_rem_sum = {1'b0, row_rem} + (RREM_W + 1)'(ROW_REM);

      src_col_in = src_col;
      src_row_in = src_row;
      dst_col_in = dst_col;
      dst_row_in = dst_row;
      nk_col_in  = nk_col;
      nk_row_in  = nk_row;
      col_rem_in = col_rem;
      row_rem_in = row_rem;

      if (keep) begin
         dst_col_in = dst_col + DCOL_W'(1);
         if (col_rem_sum >= (CREM_W + 1)'(TARGET_WIDTH)) begin
            col_rem_in = CREM_W'(col_rem_sum - (CREM_W + 1)'(TARGET_WIDTH));
            nk_col_in  = nk_col + COL_W'(COL_STEP + 1);
         end else begin
            col_rem_in = CREM_W'(col_rem_sum);
            nk_col_in  = nk_col + COL_W'(COL_STEP);
         end
      end

      if (src_col == COL_W'(SRC_COLS - 1)) begin
         src_col_in = '0;
         if (row_kept) begin
            dst_row_in = dst_row + DROW_W'(1);
            dst_col_in = '0;
            nk_col_in  = COL_W'(CROP_X);
            col_rem_in = '0;
            if (row_rem_sum >= (RREM_W + 1)'(TARGET_HEIGHT)) begin
               row_rem_in = RREM_W'(row_rem_sum - (RREM_W + 1)'(TARGET_HEIGHT));
               nk_row_in  = nk_row + ROW_W'(ROW_STEP + 1);
            end else begin
               row_rem_in = RREM_W'(row_rem_sum);
               nk_row_in  = nk_row + ROW_W'(ROW_STEP);
            end
         end
         if (src_row == ROW_W'(SRC_ROWS - 1)) begin
            // End of the source frame: restart as if a new frame began.
            src_row_in = '0;
            dst_col_in = '0;
            dst_row_in = '0;
            nk_col_in  = COL_W'(CROP_X);
            nk_row_in  = ROW_W'(CROP_Y);
            col_rem_in = '0;
            row_rem_in = '0;
         end else begin
            src_row_in = src_row + ROW_W'(1);
         end
      end else begin
         src_col_in = src_col + COL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_col_ff <= '0;
         src_row_ff <= '0;
         dst_col_ff <= '0;
         dst_row_ff <= '0;
         nk_col_ff  <= COL_W'(CROP_X);
         nk_row_ff  <= ROW_W'(CROP_Y);
         col_rem_ff <= '0;
         row_rem_ff <= '0;
      end else if (accept) begin
         src_col_ff <= src_col_in;
         src_row_ff <= src_row_in;
         dst_col_ff <= dst_col_in;
         dst_row_ff <= dst_row_in;
         nk_col_ff  <= nk_col_in;
         nk_row_ff  <= nk_row_in;
         col_rem_ff <= col_rem_in;
         row_rem_ff <= row_rem_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/ccrq_lane.sv -----
`default_nettype none

module ccrq_lane
   import ccrq_pkg::*;
(
   input  wire logic               clock,
   input  wire lane_ctrl_type      ctrl,
   input  wire logic [PIX_W-1:0]   pixel,
   input  wire logic [SCALE_W-1:0] scale,
   input  wire logic signed [7:0]  zero_point,
   output logic signed [7:0]       q
);

   logic [PROD_W-1:0]            prod_ff;
   logic signed [7:0]            q_ff, q_in;
   logic [PROD_W-FRAC_W-1:0]     whole;
   logic [FRAC_W-1:0]            frac;
   logic                         round_up;
   logic [PROD_W-FRAC_W:0]       rounded;
   logic signed [PROD_W-FRAC_W+1:0] total;

   // Round half to even, add the zero point, clamp to int8.
   always_comb begin
      whole    = prod_ff[PROD_W-1:FRAC_W];
      frac     = prod_ff[FRAC_W-1:0];
      round_up = (frac > FRAC_W'(1 << (FRAC_W - 1)))
              || ((frac == FRAC_W'(1 << (FRAC_W - 1))) && whole[0]);
      rounded  = {1'b0, whole} + (PROD_W - FRAC_W + 1)'(round_up);
      total    = $signed({1'b0, rounded})
               + $signed({{(PROD_W - FRAC_W - 6){zero_point[7]}}, zero_point});
      if (total < -(PROD_W - FRAC_W + 2)'(128)) begin
         q_in = -8'sd128;
      end else if (total > (PROD_W - FRAC_W + 2)'(127)) begin
         q_in = 8'sd127;
      end else begin
         q_in = 8'(total);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_prod) begin
         prod_ff <= PROD_W'(pixel) * PROD_W'(scale);
      end
      if (ctrl.load_out) begin
         q_ff <= q_in;
      end
   end

   assign q = q_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/center_crop_resize_int8_quantize.sv -----
`default_nettype none

// Center crop, nearest-neighbor downscale and int8 quantizer for an RGB888
// pixel stream. Source pixels arrive on the req_ channel in raster order, one
// request per pixel, with frame_start marking the first pixel of a frame.
// Pixels inside the fixed centered crop that land on the destination grid
// leave on the rsp_ channel as quantized int8 channels; all other pixels are
// consumed without a response. frame_last flags the last destination pixel.
// Both channels use valid/stall; an item moves when valid is high and stall
// is low. The csr_ port writes inv_scale (index 0, Q8.16, zero means 1.0) and
// zero_point (index 1); write only while no kept pixel is still in flight.
// Each channel is multiplied in the three lanes into the product stage, then
// rounded, offset by the zero point and clamped into the output register.
// One request is taken every cycle unless req_stall is high. When the
// receiver stalls, the output register holds its response and the product
// stage still fills, so requests keep flowing until both stages hold kept
// pixels. Reset clears the position counters to the start of a frame, sets
// inv_scale to 1.0 and zero_point to 0, and empties the pipeline.
module center_crop_resize_int8_quantize
   import ccrq_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_type                   rsp_data,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [SCALE_W-1:0]   csr_wdata
);

   logic [SCALE_W-1:0] inv_scale_ff;
   logic signed [7:0]  zero_point_ff;
   logic [SCALE_W-1:0] scale;

   logic          s1_valid_ff, s1_valid_in;
   logic          s1_last_ff;
   logic          out_valid_ff, out_valid_in;
   logic          out_last_ff;
   logic          out_go;
   logic          s1_free;
   logic          accept;
   sample_type    sample;
   lane_ctrl_type lane_ctrl;

   logic signed [7:0] q_red, q_green, q_blue;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         inv_scale_ff  <= SCALE_ONE;
         zero_point_ff <= 8'sd0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_INV_SCALE: begin
               inv_scale_ff <= csr_wdata;
            end
            CSR_ZERO_POINT: begin
               zero_point_ff <= signed'(csr_wdata[7:0]);
            end
            default: begin
            end
         endcase
      end
   end

   // A scale of zero stands for 1.0.
   assign scale = (inv_scale_ff == '0) ? SCALE_ONE : inv_scale_ff;

   // The output register frees up when empty or when its response is taken;
   // the product stage frees up when empty or when it moves forward.
   assign out_go    = !out_valid_ff || !rsp_stall;
   assign s1_free   = !s1_valid_ff || out_go;
   assign req_stall = !s1_free;
   assign accept    = req_valid && s1_free;

   ccrq_sampler u_sampler (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .frame_start (req_data.frame_start),
      .sample      (sample)
   );

   assign lane_ctrl.load_prod = accept && sample.keep;
   assign lane_ctrl.load_out  = s1_valid_ff && out_go;

   ccrq_lane u_lane_red (
      .clock      (clock),
      .ctrl       (lane_ctrl),
      .pixel      (req_data.red),
      .scale      (scale),
      .zero_point (zero_point_ff),
      .q          (q_red)
   );

   ccrq_lane u_lane_green (
      .clock      (clock),
      .ctrl       (lane_ctrl),
      .pixel      (req_data.green),
      .scale      (scale),
      .zero_point (zero_point_ff),
      .q          (q_green)
   );

   ccrq_lane u_lane_blue (
      .clock      (clock),
      .ctrl       (lane_ctrl),
      .pixel      (req_data.blue),
      .scale      (scale),
      .zero_point (zero_point_ff),
      .q          (q_blue)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_free) begin
         s1_valid_in = accept && sample.keep;
      end
      out_valid_in = out_valid_ff;
      if (out_go) begin
         out_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Frame-last marker travels alongside the lanes.
   always_ff @(posedge clock) begin
      if (lane_ctrl.load_prod) begin
         s1_last_ff <= sample.last;
      end
      if (lane_ctrl.load_out) begin
         out_last_ff <= s1_last_ff;
      end
   end

   // Merge the three lane results with the frame marker.
   assign rsp_valid           = out_valid_ff;
   assign rsp_data.q_red      = q_red;
   assign rsp_data.q_green    = q_green;
   assign rsp_data.q_blue     = q_blue;
   assign rsp_data.frame_last = out_last_ff;

   // A kept pixel that is accepted must occupy the product stage next cycle.
   assert property (@(posedge clock) disable iff (reset)
      lane_ctrl.load_prod |=> s1_valid_ff)
      else $error("kept request did not enter the product stage");

   // A held product stage must not lose its pixel.
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_go |=> s1_valid_ff && $stable(s1_last_ff))
      else $error("product stage dropped a pixel while blocked");

   // Requests are only stalled when both the product stage and the output register are full.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && out_valid_ff)
      else $error("request stalled with room in the pipeline");

endmodule

`default_nettype wire
